### rtl/kwm_pkg.sv
package kwm_pkg;

	localparam int WAY_W = 3;
	localparam int KEY_W = 32;
	localparam int PAY_W = 32;
	localparam int CFG_W = 4;

	typedef struct packed {
		logic [WAY_W-1:0] way_index;
		logic [KEY_W-1:0] tuple_key;
		logic [PAY_W-1:0] tuple_payload;
		logic             run_exhausted;
	} in_item_t;

	typedef struct packed {
		logic [WAY_W-1:0] out_way;
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic             merge_done;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic step;
		logic insert;
		logic emit;
	} kwm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_gone;
		logic way_match;
		logic search_done;
		logic list_empty;
		logic out_busy;
	} kwm_sts_t;

endpackage

### rtl/kwm_ctrl.sv
module kwm_ctrl import kwm_pkg::*; #(
	parameter int WAYS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  kwm_sts_t         sts,
	output kwm_cmd_t         cmd
);

	localparam logic [CFG_W-1:0] WAYS_SAT = (WAYS > 15) ? CFG_W'(15) : CFG_W'(WAYS);
	localparam logic [CFG_W-1:0] LOAD_MAX = CFG_W'(15);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_EMIT   = 3'b100
	} state_t;

	state_t           state_q, state_d;
	logic [CFG_W-1:0] active_ways_q;
	logic [CFG_W-1:0] loaded_q, loaded_d;
	logic             phase_q, phase_d;
	logic             emit_after_q, emit_after_d;
	logic [CFG_W-1:0] need;
	logic [CFG_W-1:0] loaded_nx;
	logic             finish;

	// effective number of ways, clamped to 1..WAYS, and to 15 at most
	always_comb begin
		if (active_ways_q == '0) begin
			need = CFG_W'(1);
		end else if (active_ways_q > WAYS_SAT) begin
			need = WAYS_SAT;
		end else begin
			need = active_ways_q;
		end
	end

	assign loaded_nx = (loaded_q == LOAD_MAX) ? loaded_q : loaded_q + CFG_W'(1);
	assign finish    = (loaded_nx >= need);
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		loaded_d     = loaded_q;
		phase_d      = phase_q;
		emit_after_d = emit_after_q;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (!phase_q) begin
						loaded_d = loaded_nx;
						if (!sts.in_gone) begin
							state_d      = ST_SEARCH;
							emit_after_d = finish;
						end else if (finish) begin
							state_d = ST_EMIT;
						end
					end else if (sts.way_match) begin
						if (!sts.in_gone) begin
							state_d      = ST_SEARCH;
							emit_after_d = 1'b1;
						end else begin
							state_d = ST_EMIT;
						end
					end
				end
			end
			ST_SEARCH: begin
				if (sts.search_done) begin
					cmd.insert = 1'b1;
					state_d    = emit_after_q ? ST_EMIT : ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
					if (sts.list_empty) begin
						phase_d  = 1'b0;
						loaded_d = '0;
					end else begin
						phase_d = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_ways_q <= CFG_W'(8);
			loaded_q      <= '0;
			phase_q       <= 1'b0;
			emit_after_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			loaded_q     <= loaded_d;
			phase_q      <= phase_d;
			emit_after_q <= emit_after_d;
			if (cfg_wr_en) begin
				active_ways_q <= cfg_wr_data;
			end
		end
	end

endmodule

### rtl/kwm_dpath.sv
module kwm_dpath import kwm_pkg::*; #(
	parameter int WAYS         = 8,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  kwm_cmd_t  cmd,
	output kwm_sts_t  sts
);

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
	localparam int IW = $clog2(WAYS);
	localparam int LW = $clog2(WAYS + 1);

	typedef struct packed {
		logic [KW-1:0]    key;
		logic [PW-1:0]    pay;
		logic [WAY_W-1:0] way;
	} entry_t;

	entry_t           list_q [WAYS];
	entry_t           item_q;
	entry_t           probe;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    pos_q;
	logic [WAY_W-1:0] awaited_q;
	logic             full;
	logic             out_valid_q;
	out_item_t        out_data_q;

	assign full  = (len_q == LW'(WAYS));
	assign probe = list_q[pos_q[IW-1:0]];

	assign sts.in_gone     = in_data.run_exhausted;
	assign sts.way_match   = (in_data.way_index == awaited_q);
	// new head goes before equal keys, so the walk stops at the first key not below it
	assign sts.search_done = full || (pos_q >= len_q) || !(probe.key < item_q.key);
	assign sts.list_empty  = (len_q == '0);
	assign sts.out_busy    = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// item register and list cells
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q.key <= KW'(in_data.tuple_key);
			item_q.pay <= PW'(in_data.tuple_payload);
			item_q.way <= in_data.way_index;
		end
		if (cmd.insert && !full) begin
			for (int k = 0; k < WAYS; k++) begin
				if (LW'(k) == pos_q) begin
					list_q[k] <= item_q;
				end else if (k > 0 && LW'(k) > pos_q && LW'(k) <= len_q) begin
					list_q[k] <= list_q[(k > 0) ? k - 1 : 0];
				end
			end
		end else if (cmd.emit) begin
			for (int k = 0; k < WAYS - 1; k++) begin
				list_q[k] <= list_q[k + 1];
			end
		end
		if (cmd.emit) begin
			if (len_q == '0) begin
				out_data_q.out_way     <= '0;
				out_data_q.out_key     <= '0;
				out_data_q.out_payload <= '0;
				out_data_q.merge_done  <= 1'b1;
			end else begin
				out_data_q.out_way     <= list_q[0].way;
				out_data_q.out_key     <= KEY_W'(list_q[0].key);
				out_data_q.out_payload <= PAY_W'(list_q[0].pay);
				out_data_q.merge_done  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_q       <= '0;
			awaited_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				pos_q <= '0;
			end else if (cmd.step) begin
				pos_q <= pos_q + LW'(1);
			end
			if (cmd.insert && !full) begin
				len_q <= len_q + LW'(1);
			end else if (cmd.emit && len_q != '0) begin
				len_q <= len_q - LW'(1);
			end
			if (cmd.emit) begin
				awaited_q <= (len_q == '0) ? '0 : list_q[0].way;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/k_way_sorted_run_merge_core.sv
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   in_data (in_item_t)
// out       output     out_valid / out_stall out_data (out_item_t)
// cfg       input      cfg_wr_en             cfg_wr_data (active_ways)
//
// a request is accepted, then walks the list to its insert position with the single
// key comparator and is inserted; once the start phase has its heads it also emits
// a request that inserts nothing skips the walk; a wrong-way refill is only captured
// reset is asynchronous: list empty, start phase, active_ways back to 8
// the result waits in an output register, so the next request is taken while it
// stalls; only a second emit waits for the register to drain
module k_way_sorted_run_merge_core import kwm_pkg::*; #(
	parameter int WAYS         = 8,
	parameter int KEY_BITS     = 32,
	parameter int PAYLOAD_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data
);

	kwm_cmd_t cmd;
	kwm_sts_t sts;

	// sequencer: start phase loading, walk, emit, end of job
	kwm_ctrl #(
		.WAYS (WAYS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	// sorted list cells, walk pointer, awaited way and output register
	kwm_dpath #(
		.WAYS         (WAYS),
		.KEY_BITS     (KEY_BITS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	// an emit never overwrites a result that is still waiting
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("emit while output register is stalled");

	// every accepted request is captured by the datapath
	a_capture_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> cmd.capture)
		else $error("accepted request not captured");

	// a result only appears after an emit command
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.emit))
		else $error("result without emit");

	// walking and accepting never overlap
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.insert) |-> in_stall)
		else $error("list walk while accepting requests");

endmodule

### test/tb_top.sv
module tb_top;
	import kwm_pkg::*;

	localparam int WAYS    = 8;
	localparam int RUN_MAX = 16;
	// cycles to let an item with no result settle: walk of the whole list plus margin
	localparam int SETTLE  = 2 * WAYS + 4;

	logic      clk;
	logic      arst_n;
	logic      cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	k_way_sorted_run_merge_core #(
		.WAYS(WAYS),
		.KEY_BITS(KEY_W),
		.PAYLOAD_BITS(PAY_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// merge predictor: sorted head list, start/running phase, active way count
	logic [KEY_W-1:0] head_key [WAYS];
	logic [PAY_W-1:0] head_pay [WAYS];
	logic [WAY_W-1:0] head_way [WAYS];
	int               head_count = 0;
	int               heads_taken = 0;
	logic [WAY_W-1:0] refill_way = '0;
	logic             merging = 1'b0;
	logic [CFG_W-1:0] active_ways = 4'd8;

	// emitted tuples and end markers still to come out of the block
	out_item_t due_emits[$];
	int        errors = 0;
	// requests that the block acts on; wrong-way refills are not counted
	int        taken_requests = 0;

	// source runs for well-formed jobs, ascending keys per way
	logic [KEY_W-1:0] run_key [WAYS][RUN_MAX];
	logic [PAY_W-1:0] run_pay [WAYS][RUN_MAX];
	int               run_len [WAYS];
	int               run_pos [WAYS];

	// traffic shaping
	logic calm = 1'b0;
	logic long_hold = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5000000;
		$display("FAIL k_way_sorted_run_merge_core");
		$finish;
	end

	// effective way count: zero acts as one, anything past WAYS as WAYS
	function automatic int ways_needed();
		if (active_ways < 1)
			return 1;
		if (active_ways > WAYS)
			return WAYS;
		return int'(active_ways);
	endfunction

	// ascending insert; an equal key lands ahead of the entries it ties with
	function automatic void insert_head(input in_item_t req);
		int pos;
		int k;
		pos = 0;
		if (head_count < WAYS) begin
			while (pos < head_count && head_key[pos] < req.tuple_key)
				pos++;
			for (k = head_count; k > pos; k--) begin
				head_key[k] = head_key[k-1];
				head_pay[k] = head_pay[k-1];
				head_way[k] = head_way[k-1];
			end
			head_key[pos] = req.tuple_key;
			head_pay[pos] = req.tuple_payload;
			head_way[pos] = req.way_index;
			head_count++;
		end
	endfunction

	// pop the smallest head, or the end marker once the list is empty
	function automatic void pop_smallest();
		out_item_t res;
		int k;
		res = '0;
		if (head_count == 0) begin
			res.merge_done = 1'b1;
			merging = 1'b0;
			heads_taken = 0;
			refill_way = '0;
		end else begin
			res.out_way = head_way[0];
			res.out_key = head_key[0];
			res.out_payload = head_pay[0];
			refill_way = head_way[0];
			for (k = 1; k < head_count; k++) begin
				head_key[k-1] = head_key[k];
				head_pay[k-1] = head_pay[k];
				head_way[k-1] = head_way[k];
			end
			head_count--;
			merging = 1'b1;
		end
		due_emits.push_back(res);
	endfunction

	// advance the merge by one accepted request
	function automatic void predict_merge(input in_item_t req);
		if (!merging) begin
			taken_requests++;
			if (!req.run_exhausted)
				insert_head(req);
			if (heads_taken < 15)
				heads_taken++;
			if (heads_taken >= ways_needed())
				pop_smallest();
		end else if (req.way_index == refill_way) begin
			taken_requests++;
			if (!req.run_exhausted)
				insert_head(req);
			pop_smallest();
		end
	endfunction

	function automatic in_item_t make_request(input int way, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay, input logic gone);
		in_item_t req;
		req.way_index = way[WAY_W-1:0];
		req.tuple_key = key;
		req.tuple_payload = pay;
		req.run_exhausted = gone;
		return req;
	endfunction

	// fresh runs: style 0 low keys full of ties, 1 spread over the whole range,
	// 2 packed against the top of the key range
	function automatic void build_runs(input int style, input int maxlen);
		int w;
		int i;
		int j;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] t;
		for (w = 0; w < WAYS; w++) begin
			run_pos[w] = 0;
			run_len[w] = $urandom_range(0, maxlen);
			k = $urandom_range(0, 3);
			for (i = 0; i < run_len[w]; i++) begin
				run_pay[w][i] = $urandom;
				if (style == 1) begin
					t = $urandom;
					for (j = i; j > 0 && run_key[w][j-1] > t; j--)
						run_key[w][j] = run_key[w][j-1];
					run_key[w][j] = t;
				end else begin
					run_key[w][i] = (style == 2) ? k + 32'hFFFF_FFDE : k;
					k += $urandom_range(0, 2);
				end
			end
		end
	endfunction

	function automatic void add_tuple(input int w, input logic [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay);
		run_key[w][run_len[w]] = key;
		run_pay[w][run_len[w]] = pay;
		run_len[w]++;
	endfunction

	// next tuple of a way, or the exhausted flag with junk key and payload;
	// a broken job refills with unordered keys instead
	function automatic in_item_t next_from_run(input int w, input logic broken);
		if (broken)
			return make_request(w, $urandom, $urandom, $urandom_range(0, 9) < 3);
		if (run_pos[w] < run_len[w]) begin
			run_pos[w]++;
			return make_request(w, run_key[w][run_pos[w]-1], run_pay[w][run_pos[w]-1], 1'b0);
		end
		return make_request(w, $urandom, $urandom, 1'b1);
	endfunction

	// offer one request, after an optional idle burst, and hold it until taken
	task automatic send_request(input in_item_t req);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
		predict_merge(req);
	endtask

	// drop valid and wait for every predicted emit to come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_emits.size() != 0)
			@(posedge clk);
	endtask

	// register write only with the block quiet
	task automatic set_active_ways(input logic [CFG_W-1:0] value);
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		active_ways = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// start phase: one head per way in shuffled order, or random ways when broken
	task automatic start_job(input logic broken);
		int order [WAYS];
		int n;
		int i;
		int j;
		int t;
		n = ways_needed();
		for (i = 0; i < WAYS; i++)
			order[i] = i;
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (i = 0; i < n; i++) begin
			if (broken)
				send_request(make_request($urandom_range(0, WAYS - 1), $urandom, $urandom,
					$urandom_range(0, 4) == 0));
			else
				send_request(next_from_run(order[i], 1'b0));
		end
	endtask

	// running phase: refill from the way just emitted until the end marker,
	// now and then slipping in a refill from some other way
	task automatic refill_until_done(input int noise_pct, input logic broken);
		while (merging) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_request(make_request(int'(refill_way) ^ int'($urandom_range(1, WAYS - 1)),
					$urandom, $urandom, 1'($urandom_range(0, 1))));
			send_request(next_from_run(int'(refill_way), broken));
		end
	endtask

	// reset value of eight ways: ties at start and on refill, key and payload
	// extremes, empty runs, a wrong-way refill
	task automatic test_default_job();
		build_runs(0, 0);
		add_tuple(0, 5, 32'h0000_0050);
		add_tuple(0, 9, 32'h0000_0090);
		add_tuple(1, 0, 32'h0000_0000);
		add_tuple(1, 5, 32'h0000_0051);
		add_tuple(2, 5, 32'h0000_0052);
		add_tuple(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_tuple(5, 5, 32'h0000_0055);
		add_tuple(7, 7, 32'h5A5A_A5A5);
		start_job(1'b0);
		send_request(make_request(int'(refill_way ^ 3'd4), 32'h8000_0000, 32'h8000_0000,
			1'b0));
		refill_until_done(0, 1'b0);
	endtask

	// zero ways acts as one: all-empty job gives the end marker at once,
	// then a one-tuple job on an odd way number
	task automatic test_register_range();
		set_active_ways(4'd0);
		send_request(make_request(5, $urandom, $urandom, 1'b1));
		send_request(make_request(3, 1, 32'h1234_5678, 1'b0));
		send_request(make_request(3, $urandom, $urandom, 1'b1));
	endtask

	// 15 acts as eight; dropping to two after two heads ends the start phase
	// on the next head; the same way twice with tied keys
	task automatic test_register_mid_start();
		build_runs(0, 0);
		set_active_ways(4'd15);
		send_request(make_request(6, 10, 32'h0000_000A, 1'b0));
		send_request(make_request(6, 10, 32'h0000_000B, 1'b0));
		set_active_ways(4'd2);
		send_request(make_request(1, 0, 0, 1'b1));
		refill_until_done(0, 1'b0);
	endtask

	// output held off for a long stretch so the block backs up into its input,
	// then a job where the sender stops mid-merge until all emits are out
	task automatic test_pressure();
		int i;
		set_active_ways(4'd8);
		build_runs(1, 12);
		long_hold = 1'b1;
		start_job(1'b0);
		refill_until_done(0, 1'b0);
		build_runs(0, 6);
		start_job(1'b0);
		for (i = 0; i < 5 && merging; i++)
			send_request(next_from_run(int'(refill_way), 1'b0));
		wait_drained();
		refill_until_done(10, 1'b0);
	endtask

	// random jobs: mostly sorted runs of random content, some broken ones,
	// with way-count changes between jobs; quiet traffic near the end
	task automatic test_random_jobs(input int count);
		int stop_at;
		logic broken;
		logic [CFG_W-1:0] value;
		stop_at = taken_requests + count;
		while (taken_requests < stop_at) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 9))
					0: begin
						value = 4'd0;
					end
					1: begin
						value = CFG_W'($urandom_range(9, 15));
					end
					default: begin
						value = CFG_W'($urandom_range(1, 8));
					end
				endcase
				set_active_ways(value);
			end
			broken = ($urandom_range(0, 5) == 0);
			build_runs($urandom_range(0, 2), $urandom_range(0, 12));
			start_job(broken);
			refill_until_done(10, broken);
			if (stop_at - taken_requests < 150)
				calm = 1'b1;
		end
	endtask

	// receiver: random stall bursts, or one long hold when asked
	initial begin
		int burst;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// emit checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_emits.size() == 0) begin
				errors++;
				$display("%0t: unexpected emit: way %0d key %h payload %h done %b", $time,
					out_data.out_way, out_data.out_key, out_data.out_payload, out_data.merge_done);
			end else begin
				want = due_emits.pop_front();
				if (out_data.out_way !== want.out_way || out_data.out_key !== want.out_key ||
						out_data.out_payload !== want.out_payload ||
						out_data.merge_done !== want.merge_done) begin
					errors++;
					$display("%0t: emit mismatch: expected way %0d key %h payload %h done %b",
						$time, want.out_way, want.out_key, want.out_payload, want.merge_done);
					$display("%0t:                got way %0d key %h payload %h done %b",
						$time, out_data.out_way, out_data.out_key, out_data.out_payload,
						out_data.merge_done);
				end
			end
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_default_job();
		test_register_range();
		test_register_mid_start();
		test_pressure();
		test_random_jobs(1250);

		// let the tail drain, then give the block time to show anything extra
		wait_drained();
		repeat (SETTLE) @(posedge clk);
		if (due_emits.size() != 0) begin
			errors++;
			$display("%0t: %0d emits never arrived, oldest expected way %0d key %h done %b",
				$time, due_emits.size(), due_emits[0].out_way, due_emits[0].out_key,
				due_emits[0].merge_done);
		end
		if (errors == 0)
			$display("PASS k_way_sorted_run_merge_core");
		else
			$display("FAIL k_way_sorted_run_merge_core");
		$finish;
	end

endmodule
